FILE: rtl/core/fsa_pkg.sv
`timescale 1ns / 1ps

package fsa_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;

    // Item count runs from 0 to STACK_DEPTH inclusive.
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);

    typedef logic [2:0] func_t;
    typedef logic [2:0] status_t;

    localparam func_t FN_PUSH  = 3'd0;
    localparam func_t FN_ADD   = 3'd1;
    localparam func_t FN_SUB   = 3'd2;
    localparam func_t FN_MUL   = 3'd3;
    localparam func_t FN_DIV   = 3'd4;
    localparam func_t FN_PRINT = 3'd5;
    localparam func_t FN_DROP  = 3'd6;
    localparam func_t FN_DUP   = 3'd7;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_UNDER = 3'd1;
    localparam status_t ST_OVER  = 3'd2;
    localparam status_t ST_DIV0  = 3'd3;
    localparam status_t ST_EMPTY = 3'd4;

endpackage

FILE: rtl/core/fsa_cmd_if.sv
`timescale 1ns / 1ps

interface fsa_cmd_if;
    import fsa_pkg::*;

    logic               valid;
    logic               ready;
    func_t              func;
    logic signed [31:0] literal;

    modport source (output valid, output func, output literal, input ready);
    modport sink   (input valid, input func, input literal, output ready);

endinterface

FILE: rtl/core/fsa_res_if.sv
`timescale 1ns / 1ps

interface fsa_res_if;
    import fsa_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] shown_value;
    logic               shown_valid;
    logic [6:0]         depth_after;
    status_t            status;

    modport source (
        output valid, output shown_value, output shown_valid,
        output depth_after, output status, input ready
    );
    modport sink (
        input valid, input shown_value, input shown_valid,
        input depth_after, input status, output ready
    );

endinterface

FILE: rtl/core/forth_data_stack_alu.sv
`timescale 1ns / 1ps

// Forth data stack with an arithmetic unit. Each beat on cmd carries one
// word (func) and a literal used only by push; each accepted word gives
// exactly one beat on res with the printed value, the depth after the
// word and a status code.
// The stack lives in a single-port-write, single-port-read RAM with a
// registered read. A word is read, worked and written back by a
// small sequencer, so one word is in flight at a time.
// Steps per word: accept while idle, capture the top item; add, sub, mul
// and div then capture the item below in a second serial read from the
// stack RAM and work the ALU; a nonzero divisor then runs the restoring
// divider, one quotient bit per cycle; last come write-back and output.
// The res beat goes valid in the same cycle that cmd is ready again.
// Results sit in an output register, so the sequencer finishes the next
// word while the receiver stalls; it only waits before loading a second
// result into a full output register.
// Reset empties the stack (the item count goes to zero) and drops any
// pending result; the RAM contents are not cleared.
module forth_data_stack_alu (
    input  logic      clk,
    input  logic      rst_n,
    fsa_cmd_if.sink   cmd,
    fsa_res_if.source res
);
    import fsa_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAP_R = 3'd1;
    localparam logic [2:0] S_CAP_L = 3'd2;
    localparam logic [2:0] S_ALU   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic                  out_valid_reg;

    func_t                 func_reg;
    logic [31:0]           lit_reg;
    logic [DATA_WIDTH-1:0] r_reg, l_reg, res_reg, rem_reg;
    logic                  neg_reg, div0_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [31:0]           pend_shown_reg, out_shown_reg;
    logic                  pend_valid_reg, out_sv_reg;
    logic [6:0]            pend_depth_reg, out_depth_reg;
    status_t               pend_status_reg, out_status_reg;

    logic [ADDR_W-1:0]     raddr, waddr;
    logic [DATA_WIDTH-1:0] rdata, wdata;
    logic                  we;

    logic [DEPTH_W-1:0]    depth_m1, depth_m2, depth_p1, pop2_depth;
    logic                  has_one, has_two, is_full;
    logic                  out_load;

    logic [DATA_WIDTH+31:0] lit_wide;
    logic [DATA_WIDTH-1:0]  lit_ext;
    logic [DATA_WIDTH+31:0] shown_wide;
    logic [DEPTH_W+6:0]     depth_wide;
    logic [DATA_WIDTH-1:0]  sum, dif, prod, l_mag, r_mag, quot_signed;
    logic [DATA_WIDTH+1:0]  trial;
    logic [DATA_WIDTH-1:0]  shifted;
    status_t                wb_status;
    logic                   wb_shown_valid;

    assign depth_m1   = depth_reg - DEPTH_W'(1);
    assign depth_m2   = depth_reg - DEPTH_W'(2);
    assign depth_p1   = depth_reg + DEPTH_W'(1);
    assign has_one    = depth_reg != '0;
    assign has_two    = depth_reg >= DEPTH_W'(2);
    assign is_full    = depth_reg == DEPTH_W'(STACK_DEPTH);
    assign pop2_depth = has_two ? depth_m2 : '0;

    assign lit_wide   = {{DATA_WIDTH{lit_reg[31]}}, lit_reg};
    assign lit_ext    = lit_wide[DATA_WIDTH-1:0];
    assign shown_wide = {{32{r_reg[DATA_WIDTH-1]}}, r_reg};
    assign depth_wide = {7'b0, depth_next};

    assign sum   = l_reg + r_reg;
    assign dif   = l_reg - r_reg;
    assign prod  = l_reg * r_reg;
    assign l_mag = l_reg[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - l_reg) : l_reg;
    assign r_mag = r_reg[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - r_reg) : r_reg;

    // One restoring step: l_reg shifts out dividend bits and takes quotient bits.
    assign shifted     = {rem_reg[DATA_WIDTH-2:0], l_reg[DATA_WIDTH-1]};
    assign trial       = {1'b0, rem_reg, l_reg[DATA_WIDTH-1]} - {2'b0, r_reg};
    // A finished divide leaves the unsigned quotient in l_reg.
    assign quot_signed = neg_reg ? (DATA_WIDTH'(0) - l_reg) : l_reg;

    // The read for the top item goes out while idle, so its data is ready
    // in the first working cycle; the item below follows in the next cycle.
    always_comb
    begin
        raddr = depth_m1[ADDR_W-1:0];
        if (state_reg == S_CAP_R)
        begin
            raddr = depth_m2[ADDR_W-1:0];
        end
    end

    // Write-back: memory write, new depth and the result fields.
    always_comb
    begin
        we             = 1'b0;
        waddr          = depth_reg[ADDR_W-1:0];
        wdata          = r_reg;
        depth_next     = depth_reg;
        wb_status      = ST_OK;
        wb_shown_valid = 1'b0;
        if (state_reg == S_WB)
        begin
            case (func_reg)
                FN_PUSH:
                begin
                    if (is_full)
                    begin
                        wb_status = ST_OVER;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wdata      = lit_ext;
                        depth_next = depth_p1;
                    end
                end
                FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                begin
                    we         = 1'b1;
                    waddr      = pop2_depth[ADDR_W-1:0];
                    wdata      = (func_reg == FN_DIV && !div0_reg) ? quot_signed : res_reg;
                    depth_next = pop2_depth + DEPTH_W'(1);
                    if (!has_two)
                    begin
                        wb_status = ST_UNDER;
                    end
                    else if (div0_reg)
                    begin
                        wb_status = ST_DIV0;
                    end
                end
                FN_PRINT:
                begin
                    if (has_one)
                    begin
                        wb_shown_valid = 1'b1;
                        depth_next     = depth_m1;
                    end
                    else
                    begin
                        wb_status = ST_EMPTY;
                    end
                end
                FN_DROP:
                begin
                    if (has_one)
                    begin
                        depth_next = depth_m1;
                    end
                    else
                    begin
                        wb_status = ST_UNDER;
                    end
                end
                default:
                begin
                    // Dup: r_reg already reads as zero on an empty stack.
                    if (is_full)
                    begin
                        wb_status = ST_OVER;
                    end
                    else
                    begin
                        we         = 1'b1;
                        depth_next = depth_p1;
                    end
                end
            endcase
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_CAP_R;
                end
            end
            S_CAP_R:
            begin
                if (func_reg == FN_ADD || func_reg == FN_SUB ||
                    func_reg == FN_MUL || func_reg == FN_DIV)
                begin
                    state_next = S_CAP_L;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_CAP_L:
            begin
                state_next = S_ALU;
            end
            S_ALU:
            begin
                if (func_reg == FN_DIV && r_reg != '0)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg <= cmd.func;
                lit_reg  <= cmd.literal;
            end
            S_CAP_R:
            begin
                r_reg <= has_one ? rdata : '0;
            end
            S_CAP_L:
            begin
                l_reg <= has_two ? rdata : '0;
            end
            S_ALU:
            begin
                div0_reg <= 1'b0;
                case (func_reg)
                    FN_ADD: res_reg <= sum;
                    FN_SUB: res_reg <= dif;
                    FN_MUL: res_reg <= prod;
                    default:
                    begin
                        res_reg  <= '0;
                        div0_reg <= r_reg == '0;
                        l_reg    <= l_mag;
                        r_reg    <= r_mag;
                        rem_reg  <= '0;
                        neg_reg  <= l_reg[DATA_WIDTH-1] ^ r_reg[DATA_WIDTH-1];
                        cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
                    end
                endcase
            end
            S_DIV:
            begin
                if (trial[DATA_WIDTH+1])
                begin
                    rem_reg <= shifted;
                    l_reg   <= {l_reg[DATA_WIDTH-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial[DATA_WIDTH-1:0];
                    l_reg   <= {l_reg[DATA_WIDTH-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            S_WB:
            begin
                pend_shown_reg  <= wb_shown_valid ? shown_wide[31:0] : '0;
                pend_valid_reg  <= wb_shown_valid;
                pend_depth_reg  <= depth_wide[6:0];
                pend_status_reg <= wb_status;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_shown_reg  <= pend_shown_reg;
            out_sv_reg     <= pend_valid_reg;
            out_depth_reg  <= pend_depth_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    fsa_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cmd.ready       = state_reg == S_IDLE;
    assign res.valid       = out_valid_reg;
    assign res.shown_value = out_shown_reg;
    assign res.shown_valid = out_sv_reg;
    assign res.depth_after = out_depth_reg;
    assign res.status      = out_status_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_depth_only_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WB) |=> $stable(depth_reg))
        else $error("stack depth changed outside write-back");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |=>
            (depth_reg == $past(depth_reg) ||
             depth_reg == $past(depth_reg) + DEPTH_W'(1) ||
             depth_reg == $past(depth_reg) - DEPTH_W'(1)))
        else $error("stack depth moved by more than one item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(out_shown_reg)))
        else $error("pending result overwritten or lost");

    a_shown_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sv_reg) |-> (out_status_reg == ST_OK))
        else $error("printed value with an error status");

endmodule

FILE: rtl/core/fsa_ram.sv
`timescale 1ns / 1ps

module fsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
